FILE: design/breu_pkg.sv
// package: types, opcodes and constants of the register execute unit
package breu_pkg;

    localparam int REG_COUNT_DEF = 16;
    localparam int XW = 64;
    localparam int IDXW = 4;
    localparam int QDEPTH = 2;

    typedef enum logic [4:0] {
        OP_ADD   = 5'd0,  OP_SUB   = 5'd1,  OP_MUL   = 5'd2,  OP_UDIV  = 5'd3,
        OP_SDIV  = 5'd4,  OP_EQ64  = 5'd5,  OP_EQ8   = 5'd6,  OP_NEQ8  = 5'd7,
        OP_ULT   = 5'd8,  OP_UGT   = 5'd9,  OP_SLT   = 5'd10, OP_SGT   = 5'd11,
        OP_OR    = 5'd12, OP_XOR   = 5'd13, OP_AND   = 5'd14, OP_SHL   = 5'd15,
        OP_SHR   = 5'd16, OP_SAR   = 5'd17, OP_LEA   = 5'd18, OP_NEG   = 5'd19,
        OP_SET64 = 5'd20, OP_SET32 = 5'd21, OP_SET16 = 5'd22, OP_SET8  = 5'd23,
        OP_CPY64 = 5'd24, OP_CPY32 = 5'd25, OP_CPY16 = 5'd26, OP_CPY8  = 5'd27,
        OP_ZX8   = 5'd28, OP_SX8   = 5'd29, OP_ZX32  = 5'd30, OP_SX32  = 5'd31
    } t_op;

    // operation class picked by the front end
    typedef enum logic [1:0] {
        CL_SIMPLE = 2'd0,
        CL_MUL    = 2'd1,
        CL_DIV    = 2'd2,
        CL_LEA    = 2'd3
    } t_class;

    // back-end sequencer states
    typedef enum logic [2:0] {
        ST_IDLE  = 3'd0,
        ST_READ  = 3'd1,
        ST_MUL   = 3'd2,
        ST_DIV   = 3'd3,
        ST_LEA   = 3'd4,
        ST_WRITE = 3'd5
    } t_state;

    typedef struct packed {
        t_op              op;
        t_class           cls;
        logic [IDXW-1:0]  dest;
        logic [IDXW-1:0]  src;
        logic [IDXW-1:0]  idx;
        logic [3:0]       scale;
        logic [31:0]      disp;
        logic [XW-1:0]    imm;
    } t_cmd;

    typedef struct packed {
        logic [XW-1:0] written_value;
        logic          divide_fault;
    } t_res;

endpackage

FILE: design/breu_if.sv
// valid/ready channel carrying one payload
interface breu_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

FILE: design/breu_front.sv
// front end: accepts a beat, classifies it and queues it for the back end
module breu_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    breu_if.sink              i_req,
    output breu_pkg::t_cmd    o_cmd,
    output logic              o_cmd_valid,
    input  logic              i_cmd_take
);
    localparam int QPW = $clog2(breu_pkg::QDEPTH);

    breu_pkg::t_cmd r_q [breu_pkg::QDEPTH];
    logic [QPW-1:0] r_wp, r_rp;
    logic [QPW:0]   r_cnt;
    breu_pkg::t_cmd w_cmd;
    logic           w_push, w_pop;

    // classify the incoming opcode
    always_comb begin
        w_cmd = i_req.data;
        case (i_req.data.op)
            breu_pkg::OP_MUL:  w_cmd.cls = breu_pkg::CL_MUL;
            breu_pkg::OP_UDIV: w_cmd.cls = breu_pkg::CL_DIV;
            breu_pkg::OP_SDIV: w_cmd.cls = breu_pkg::CL_DIV;
            breu_pkg::OP_LEA:  w_cmd.cls = breu_pkg::CL_LEA;
            default:           w_cmd.cls = breu_pkg::CL_SIMPLE;
        endcase
    end

    assign i_req.ready = (r_cnt != (QPW+1)'(breu_pkg::QDEPTH));
    assign w_push = i_req.valid && i_req.ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign w_pop = i_cmd_take && o_cmd_valid;
    assign o_cmd = r_q[r_rp];

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    // queue pointers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= '0;
            r_rp <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 1'b1;
            if (w_pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + (QPW+1)'(w_push) - (QPW+1)'(w_pop);
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (QPW+1)'(breu_pkg::QDEPTH))
        else $error("queue overflow");
    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_push && !w_pop) |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("queue count");
    a_pop_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == '0) |-> !w_pop)
        else $error("pop of empty queue");
`endif
endmodule

FILE: design/breu_div.sv
// 64-bit radix-2 unsigned divider, one quotient bit per cycle
module breu_div (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_start,
    input  logic [breu_pkg::XW-1:0] i_num,
    input  logic [breu_pkg::XW-1:0] i_den,
    output logic                    o_done,
    output logic [breu_pkg::XW-1:0] o_quo
);
    localparam int XW = breu_pkg::XW;
    localparam int CW = $clog2(XW) + 1;

    logic [XW-1:0] r_quo, r_den;
    logic [XW-1:0] r_rem;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic [XW:0]   w_sh, w_sub;

    assign w_sh = {r_rem, r_quo[XW-1]};
    assign w_sub = w_sh - {1'b0, r_den};
    assign o_done = r_busy && (r_cnt == '0);
    assign o_quo = r_quo;

    // shift-subtract step
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy && r_cnt != '0) begin
            if (!w_sub[XW]) begin
                r_rem <= w_sub[XW-1:0];
                r_quo <= {r_quo[XW-2:0], 1'b1};
            end else begin
                r_rem <= w_sh[XW-1:0];
                r_quo <= {r_quo[XW-2:0], 1'b0};
            end
        end
    end

    // step counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt <= CW'(XW);
        end else if (r_busy) begin
            if (r_cnt == '0) r_busy <= 1'b0;
            else r_cnt <= r_cnt - 1'b1;
        end
    end
endmodule

FILE: design/breu_back.sv
// back end: register file, operand read, execution units and result register
module breu_back #(
    parameter int REG_COUNT = breu_pkg::REG_COUNT_DEF
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  breu_pkg::t_cmd i_cmd,
    input  logic           i_cmd_valid,
    output logic           o_cmd_take,
    breu_if.source         o_res
);
    localparam int XW = breu_pkg::XW;
    localparam int RW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;

    breu_pkg::t_state r_st, n_st;
    breu_pkg::t_cmd   r_cmd;
    logic [XW-1:0]    r_rf [REG_COUNT];
    logic [XW-1:0]    r_a, r_b, r_x, r_acc, r_r;
    logic [XW-1:0]    r_mlo, r_mhi;
    logic [XW-1:0]    r_wval;
    logic             r_mph;
    logic             r_fault, r_ovalid, r_sgn;
    logic [XW-1:0]    w_simple, w_div_num, w_div_den, w_dq;
    logic             w_div_start, w_div_done, w_fin;
    logic [RW-1:0]    w_d, w_s, w_x;

    // register index taken modulo the file size by at most four subtractions (exact for REG_COUNT >= 4)
    function automatic logic [RW-1:0] sel(input logic [breu_pkg::IDXW-1:0] i);
        logic [breu_pkg::IDXW+8:0] t;
        t = (breu_pkg::IDXW+9)'(i);
        for (int k = 0; k < 4; k++) begin
            if (t >= (breu_pkg::IDXW+9)'(REG_COUNT)) begin
                t = t - (breu_pkg::IDXW+9)'(REG_COUNT);
            end
        end
        return t[RW-1:0];
    endfunction

    assign w_d = sel(r_cmd.dest);
    assign w_s = sel(r_cmd.src);
    assign w_x = sel(r_cmd.idx);

    // simple operations, computed combinationally
    always_comb begin
        logic [5:0] sh;
        sh = r_b[5:0];
        w_simple = r_a;
        case (r_cmd.op)
            breu_pkg::OP_ADD:   w_simple = r_a + r_b;
            breu_pkg::OP_SUB:   w_simple = r_a - r_b;
            breu_pkg::OP_EQ64:  w_simple = XW'(r_a == r_b);
            breu_pkg::OP_EQ8:   w_simple = {r_a[XW-1:8], 7'd0, r_a[7:0] == r_b[7:0]};
            breu_pkg::OP_NEQ8:  w_simple = {r_a[XW-1:8], 7'd0, r_a[7:0] != r_b[7:0]};
            breu_pkg::OP_ULT:   w_simple = XW'(r_a < r_b);
            breu_pkg::OP_UGT:   w_simple = XW'(r_a > r_b);
            breu_pkg::OP_SLT:   w_simple = XW'($signed(r_a) < $signed(r_b));
            breu_pkg::OP_SGT:   w_simple = XW'($signed(r_a) > $signed(r_b));
            breu_pkg::OP_OR:    w_simple = r_a | r_b;
            breu_pkg::OP_XOR:   w_simple = r_a ^ r_b;
            breu_pkg::OP_AND:   w_simple = r_a & r_b;
            breu_pkg::OP_SHL:   w_simple = r_a << sh;
            breu_pkg::OP_SHR:   w_simple = r_a >> sh;
            breu_pkg::OP_SAR:   w_simple = XW'($signed(r_a) >>> sh);
            breu_pkg::OP_NEG:   w_simple = '0 - r_a;
            breu_pkg::OP_SET64: w_simple = r_cmd.imm;
            breu_pkg::OP_SET32: w_simple = {r_a[XW-1:32], r_cmd.imm[31:0]};
            breu_pkg::OP_SET16: w_simple = {r_a[XW-1:16], r_cmd.imm[15:0]};
            breu_pkg::OP_SET8:  w_simple = {r_a[XW-1:8], r_cmd.imm[7:0]};
            breu_pkg::OP_CPY64: w_simple = r_b;
            breu_pkg::OP_CPY32: w_simple = {32'd0, r_b[31:0]};
            breu_pkg::OP_CPY16: w_simple = {r_a[XW-1:16], r_b[15:0]};
            breu_pkg::OP_CPY8:  w_simple = {r_a[XW-1:8], r_b[7:0]};
            breu_pkg::OP_ZX8:   w_simple = {56'd0, r_a[7:0]};
            breu_pkg::OP_SX8:   w_simple = {{56{r_a[7]}}, r_a[7:0]};
            breu_pkg::OP_ZX32:  w_simple = {32'd0, r_a[31:0]};
            breu_pkg::OP_SX32:  w_simple = {{32{r_a[31]}}, r_a[31:0]};
            default:            w_simple = r_a;
        endcase
    end

    // divider operands as magnitudes for signed divide
    assign w_div_num = (r_cmd.op == breu_pkg::OP_SDIV && r_a[XW-1]) ? '0 - r_a : r_a;
    assign w_div_den = (r_cmd.op == breu_pkg::OP_SDIV && r_b[XW-1]) ? '0 - r_b : r_b;
    assign w_div_start = (r_st == breu_pkg::ST_DIV) && !r_mph && (r_b != '0);

    breu_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_dq)
    );

    // next state
    always_comb begin
        n_st = r_st;
        case (r_st)
            breu_pkg::ST_IDLE:  if (i_cmd_valid) n_st = breu_pkg::ST_READ;
            breu_pkg::ST_READ: begin
                case (r_cmd.cls)
                    breu_pkg::CL_MUL: n_st = breu_pkg::ST_MUL;
                    breu_pkg::CL_DIV: n_st = breu_pkg::ST_DIV;
                    breu_pkg::CL_LEA: n_st = breu_pkg::ST_LEA;
                    default:          n_st = breu_pkg::ST_WRITE;
                endcase
            end
            breu_pkg::ST_MUL:   if (r_mph) n_st = breu_pkg::ST_WRITE;
            breu_pkg::ST_DIV:   if (r_b == '0 || w_div_done) n_st = breu_pkg::ST_WRITE;
            breu_pkg::ST_LEA:   if (r_mph) n_st = breu_pkg::ST_WRITE;
            breu_pkg::ST_WRITE: if (!r_ovalid || o_res.ready) n_st = breu_pkg::ST_IDLE;
            default:            n_st = breu_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb begin
        o_cmd_take = (r_st == breu_pkg::ST_IDLE);
        w_fin = (r_st == breu_pkg::ST_WRITE) && (!r_ovalid || o_res.ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_st <= breu_pkg::ST_IDLE;
        else r_st <= n_st;
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_st == breu_pkg::ST_IDLE && i_cmd_valid) r_cmd <= i_cmd;
        // phase flag: second step of mul and lea, divider started
        r_mph <= (r_st == breu_pkg::ST_DIV)
              || (((r_st == breu_pkg::ST_MUL) || (r_st == breu_pkg::ST_LEA)) && !r_mph);
        case (r_st)
            breu_pkg::ST_READ: begin
                r_a <= r_rf[w_d];
                r_b <= r_rf[w_s];
                r_x <= r_rf[w_x];
            end
            breu_pkg::ST_MUL: begin
                // low and one cross 32-bit partial product first, then the other cross product and the sum
                if (!r_mph) begin
                    r_mlo <= {32'd0, r_a[31:0]} * {32'd0, r_b[31:0]};
                    r_mhi <= {32'(r_a[31:0] * r_b[63:32]), 32'd0};
                end else begin
                    r_r <= r_mlo + r_mhi + {32'(r_a[63:32] * r_b[31:0]), 32'd0};
                end
            end
            breu_pkg::ST_LEA: begin
                if (!r_mph) begin
                    r_acc <= r_x * XW'(r_cmd.scale);
                end else begin
                    r_r <= r_b + {{32{r_cmd.disp[31]}}, r_cmd.disp}
                         + ((r_cmd.scale != 4'd0) ? r_acc : '0);
                end
            end
            breu_pkg::ST_DIV: begin
                r_sgn <= (r_cmd.op == breu_pkg::OP_SDIV) && (r_a[XW-1] ^ r_b[XW-1]);
                if (r_b == '0) begin
                    r_r <= '1;
                end else if (w_div_done) begin
                    r_r <= r_sgn ? '0 - w_dq : w_dq;
                end
            end
            breu_pkg::ST_WRITE: if (r_cmd.cls == breu_pkg::CL_SIMPLE) r_r <= w_simple;
            default: ;
        endcase
    end

    // register file
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < REG_COUNT; i++) r_rf[i] <= '0;
        end else if (w_fin) begin
            r_rf[w_d] <= (r_cmd.cls == breu_pkg::CL_SIMPLE) ? w_simple : r_r;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_wval <= (r_cmd.cls == breu_pkg::CL_SIMPLE) ? w_simple : r_r;
            r_fault <= (r_cmd.cls == breu_pkg::CL_DIV) && (r_b == '0);
        end
    end
    assign o_res.data = breu_pkg::t_res'{written_value: r_wval, divide_fault: r_fault};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ovalid <= 1'b0;
        else if (w_fin) r_ovalid <= 1'b1;
        else if (o_res.ready) r_ovalid <= 1'b0;
    end
    assign o_res.valid = r_ovalid;

`ifndef SYNTHESIS
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |-> r_st == breu_pkg::ST_IDLE)
        else $error("command taken while busy");
    a_fin_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fin |=> r_ovalid)
        else $error("result lost");
    a_fault_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fin && r_cmd.cls != breu_pkg::CL_DIV) |=> !r_fault)
        else $error("fault without divide");
`endif
endmodule

FILE: design/bytecode_register_execute_unit_core.sv
// top level of the bytecode register execute unit
// Executes one register instruction per beat on a REG_COUNT x 64-bit register
// file and returns the full new value of the destination register. A two-entry
// queue decouples the request port from the execution sequencer, which handles
// one instruction at a time. Simple ops go from operand read straight to write;
// multiply (two-step 32-bit partial product multiplier) and load-address take two steps;
// divide uses a radix-2 divider, one quotient bit a cycle, and skips it when the divisor is
// zero; the next instruction starts once the result is in the output register,
// and a result that is not taken stalls the sequencer. Registers reset to zero.
module bytecode_register_execute_unit_core #(
    parameter int REG_COUNT = breu_pkg::REG_COUNT_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    breu_if.sink  i_req,
    breu_if.source o_res
);
    breu_pkg::t_cmd w_cmd;
    logic           w_cmd_valid, w_cmd_take;

    breu_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_take  (w_cmd_take)
    );

    breu_back #(.REG_COUNT(REG_COUNT)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_take  (w_cmd_take),
        .o_res       (o_res)
    );
endmodule
